### src/pyr_pkg.sv
// ----------------------------------------------------------------------------
// pyr_pkg: shared types and constants of the pyramid reduce block
// Holds the job record passed from front to back, the vertical tap mode
// and the 1-4-6-4-1 tap arithmetic used by both filter passes.
// ----------------------------------------------------------------------------
package pyr_pkg;

  localparam int PIX_W     = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MIN_DIM   = 4;
  localparam int SUM_W     = 21;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  typedef logic signed [PIX_W-1:0] pix_t;

  // vertical tap arrangement: interior, first output row, last row of even height
  typedef enum logic [1:0] {
    VS_MID = 2'd0,
    VS_TOP = 2'd1,
    VS_BOT = 2'd2
  } vsel_t;

  typedef struct packed {
    pix_t [4:0]  taps;
    vsel_t       vsel;
    logic [1:0]  wrow;
    logic        emit;
    logic        row_end;
    logic        frame_end;
  } job_t;

  // (a+e+4(b+d)+6c+8) >> 4, floor shift
  function automatic pix_t tap5(input pix_t a, input pix_t b, input pix_t c,
                                input pix_t d, input pix_t e);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] sh;
    s  = SUM_W'(a) + SUM_W'(e) + ((SUM_W'(b) + SUM_W'(d)) <<< 2)
       + SUM_W'(c) * 21'sd6 + 21'sd8;
    sh = s >>> 4;
    return sh[PIX_W-1:0];
  endfunction

endpackage

### src/pyr_ram.sv
// ----------------------------------------------------------------------------
// pyr_ram: generic single-write, single-read RAM
// Registered read; a read of the address being written returns old data.
// ----------------------------------------------------------------------------
module pyr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pyr_front.sv
// ----------------------------------------------------------------------------
// pyr_front: input side of the pyramid reduce
// Tracks column and row, keeps the last four pixels, and turns each pixel
// that completes a horizontal tap into a job for the back end.
// ----------------------------------------------------------------------------
module pyr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pyr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pyr_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 take,
  input  pyr_pkg::pix_t                        pixel_in,
  output logic                                 push,
  output pyr_pkg::job_t                        job,
  output logic [$clog2(MAX_WIDTH/2)-1:0]       ox
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int AW  = $clog2(MAX_WIDTH / 2);
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > pyr_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : pyr_pkg::CFG_W;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > pyr_pkg::CFG_W) ?
                       $clog2(MAX_HEIGHT + 1) : pyr_pkg::CFG_W;

  logic [pyr_pkg::CFG_W-1:0] width_cfg;
  logic [pyr_pkg::CFG_W-1:0] height_cfg;
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  pyr_pkg::pix_t             win [4];

  logic [WDW-1:0] wd, w;
  logic [HDW-1:0] hd, h;
  logic           last_col, last_row;
  logic           h_end, h_mid, v_end, v_mid;
  logic [CW-1:0]  cc;
  logic [RW-1:0]  cr;
  logic [HDW-1:0] oy;

  // clamp the programmed size
  always_comb begin
    wd = WDW'(width_cfg);
    hd = HDW'(height_cfg);
    if (wd < WDW'(pyr_pkg::MIN_DIM)) begin
      w = WDW'(pyr_pkg::MIN_DIM);
    end else if (wd > WDW'(MAX_WIDTH)) begin
      w = WDW'(MAX_WIDTH);
    end else begin
      w = wd;
    end
    if (hd < HDW'(pyr_pkg::MIN_DIM)) begin
      h = HDW'(pyr_pkg::MIN_DIM);
    end else if (hd > HDW'(MAX_HEIGHT)) begin
      h = HDW'(MAX_HEIGHT);
    end else begin
      h = hd;
    end
  end

  // classify the pixel position
  always_comb begin
    last_col = (WDW'(col) == w - WDW'(1));
    last_row = (HDW'(row) == h - HDW'(1));
    h_end    = last_col && !w[0];
    h_mid    = !col[0] && (col != '0);
    v_end    = last_row && !h[0];
    v_mid    = !row[0] && (row != '0);
    cc       = h_end ? col - CW'(1) : col - CW'(2);
    cr       = v_end ? row - RW'(1) : row - RW'(2);
    ox       = cc[AW:1];
    oy       = HDW'(cr[RW-1:1]);
  end

  // build the job
  always_comb begin
    push          = take && (h_mid || h_end);
    job.wrow      = row[1:0];
    job.emit      = v_mid || v_end;
    job.row_end   = (WDW'(ox) == (w >> 1) - WDW'(1));
    job.frame_end = job.row_end && (oy == (h >> 1) - HDW'(1));
    if (v_end) begin
      job.vsel = pyr_pkg::VS_BOT;
    end else if (row == RW'(2)) begin
      job.vsel = pyr_pkg::VS_TOP;
    end else begin
      job.vsel = pyr_pkg::VS_MID;
    end
    if (h_end) begin
      job.taps = {win[2], win[1], win[0], pixel_in, pixel_in};
    end else if (col == CW'(2)) begin
      job.taps = {win[1], win[1], win[1], win[0], pixel_in};
    end else begin
      job.taps = {win[3], win[2], win[1], win[0], pixel_in};
    end
  end

  // advance position and pixel history; a write to the width or height register restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= pyr_pkg::DIM_RESET;
      height_cfg <= pyr_pkg::DIM_RESET;
      col        <= '0;
      row        <= '0;
      for (int i = 0; i < 4; i++) win[i] <= '0;
    end else begin
      if (take) begin
        win[3] <= win[2];
        win[2] <= win[1];
        win[1] <= win[0];
        win[0] <= pixel_in;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (cfg_write && (cfg_index == pyr_pkg::REG_WIDTH ||
                        cfg_index == pyr_pkg::REG_HEIGHT)) begin
        if (cfg_index == pyr_pkg::REG_WIDTH) begin
          width_cfg <= cfg_data;
        end else begin
          height_cfg <= cfg_data;
        end
        col <= '0;
        row <= '0;
        for (int i = 0; i < 4; i++) win[i] <= '0;
      end
    end
  end

endmodule

### src/pyr_queue.sv
// ----------------------------------------------------------------------------
// pyr_queue: short job queue between front and back
// Ring of registers with read and write pointers and a fill level.
// ----------------------------------------------------------------------------
module pyr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       valid,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  assign dout  = slots[rd_ptr];
  assign valid = (level != '0);
  assign full  = (level == LW'(DEPTH));

  // store pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // move pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

### src/pyr_back.sv
// ----------------------------------------------------------------------------
// pyr_back: filter side of the pyramid reduce
// Runs the horizontal tap, writes and reads the four line stores, runs the
// vertical tap and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module pyr_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  pyr_pkg::job_t                  job,
  input  logic [$clog2(MAX_WIDTH/2)-1:0] ox,
  output logic                           pop,
  output pyr_pkg::pix_t                  pixel_out,
  output logic                           row_end,
  output logic                           frame_end,
  output logic                           out_valid,
  input  logic                           out_stall
);

  localparam int HALF = MAX_WIDTH / 2;
  localparam int AW   = $clog2(HALF);

  typedef struct packed {
    pyr_pkg::pix_t hv;
    pyr_pkg::vsel_t vsel;
    logic [1:0]    wrow;
    logic          emit;
    logic          row_end;
    logic          frame_end;
  } stage_t;

  logic          out_free;
  logic          s1_valid;
  stage_t        s1;
  pyr_pkg::pix_t hv;
  pyr_pkg::pix_t rd [4];
  pyr_pkg::pix_t v0, v1, v2, v3, v4;

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_valid && (!s1_valid || out_free);
  assign hv       = pyr_pkg::tap5(job.taps[4], job.taps[3], job.taps[2],
                                  job.taps[1], job.taps[0]);

  // one line store per input row modulo four
  for (genvar k = 0; k < 4; k++) begin : g_line
    pyr_ram #(
      .WIDTH(pyr_pkg::PIX_W),
      .DEPTH(HALF)
    ) u_line (
      .clk  (clk),
      .we   (pop && (job.wrow == 2'(k))),
      .waddr(AW'(ox)),
      .wdata(hv),
      .re   (pop),
      .raddr(AW'(ox)),
      .rdata(rd[k])
    );
  end

  // hold horizontal result while the line stores are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1.hv        <= hv;
      s1.vsel      <= job.vsel;
      s1.wrow      <= job.wrow;
      s1.emit      <= job.emit;
      s1.row_end   <= job.row_end;
      s1.frame_end <= job.frame_end;
    end
  end

  // pick vertical taps from rows one to four back
  always_comb begin
    case (s1.vsel)
      pyr_pkg::VS_TOP: begin
        v0 = rd[2'(s1.wrow - 2'd2)];
        v1 = v0;
        v2 = v0;
        v3 = rd[2'(s1.wrow - 2'd1)];
        v4 = s1.hv;
      end
      pyr_pkg::VS_BOT: begin
        v0 = rd[2'(s1.wrow - 2'd3)];
        v1 = rd[2'(s1.wrow - 2'd2)];
        v2 = rd[2'(s1.wrow - 2'd1)];
        v3 = s1.hv;
        v4 = s1.hv;
      end
      default: begin
        v0 = rd[s1.wrow];
        v1 = rd[2'(s1.wrow - 2'd3)];
        v2 = rd[2'(s1.wrow - 2'd2)];
        v3 = rd[2'(s1.wrow - 2'd1)];
        v4 = s1.hv;
      end
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      pixel_out <= pyr_pkg::tap5(v0, v1, v2, v3, v4);
      row_end   <= s1.row_end;
      frame_end <= s1.frame_end;
    end
  end

endmodule

### src/pyramid_reduce_binomial_5tap.sv
// ----------------------------------------------------------------------------
// pyramid_reduce_binomial_5tap: one Gaussian pyramid reduce level
// Path: the input beat that completes a 5x5 neighborhood becomes a job that
// passes the job queue, the horizontal hold register and the output beat
// register. Throughput: one pixel per cycle while the job queue is not full,
// set by the single horizontal tap unit. Reset: size registers return to
// 1024x1024, the frame restarts at row 0, column 0; line stores are not cleared.
// ----------------------------------------------------------------------------
module pyramid_reduce_binomial_5tap #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pyr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pyr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            pixel_out,
  output logic                          row_end,
  output logic                          frame_end
);

  localparam int AW    = $clog2(MAX_WIDTH / 2);
  localparam int JW    = $bits(pyr_pkg::job_t);
  localparam int QW    = JW + AW;
  localparam int QDEPTH = 4;

  logic                          take;
  logic                          push;
  pyr_pkg::job_t                 f_job;
  logic [AW-1:0]                 f_ox;
  logic [QW-1:0]                 q_dout;
  logic                          q_valid, q_full, pop;
  logic [$clog2(QDEPTH+1)-1:0]   q_level;
  pyr_pkg::job_t                 b_job;
  logic [AW-1:0]                 b_ox;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign b_job    = q_dout[QW-1:AW];
  assign b_ox     = q_dout[AW-1:0];

  pyr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .pixel_in (pixel_in),
    .push     (push),
    .job      (f_job),
    .ox       (f_ox)
  );

  pyr_queue #(
    .W    (QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({f_job, f_ox}),
    .pop  (pop),
    .dout (q_dout),
    .valid(q_valid),
    .full (q_full),
    .level(q_level)
  );

  pyr_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .job      (b_job),
    .ox       (b_ox),
    .pop      (pop),
    .pixel_out(pixel_out),
    .row_end  (row_end),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  // last pixel of the frame always closes a row
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end))
    else $error("frame_end without row_end");

  // queue never overfills
  a_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("job queue overflow");

  // a pushed job leaves the queue non-empty
  a_push: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("pushed job lost");

  // pops only from a non-empty queue
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_level != '0)
    else $error("pop from empty queue");

endmodule
